// ----- rtl/core/cln_pkg.sv -----
// Shared types, constants and the control store for the character LCD nibble writer.
// Used by cln_sequencer, cln_datapath and char_lcd_nibble_writer; depends on nothing.

package cln_pkg;

	// Default depth of the digit stack
	localparam int MAX_DIGITS_DEF = 10;

	// Byte constants for the display controller
	localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
	localparam logic [7:0] ROW1_OFFSET   = 8'h40;
	localparam logic [7:0] MINUS_CHAR    = 8'h2D;
	localparam logic [3:0] DIGIT_HI      = 4'h3;   // ASCII '0' is 0x30
	localparam logic [7:0] ROW_MAX       = 8'd1;
	localparam logic [7:0] COL_MAX       = 8'd15;

	// ceil(2^35 / 10): q = (x * RECIP10) >> 35 is exact for all 32-bit x
	localparam logic [31:0] RECIP10      = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT  = 35;

	typedef enum logic [1:0] {
		FUNC_CMD    = 2'd0,
		FUNC_CHAR   = 2'd1,
		FUNC_CURSOR = 2'd2,
		FUNC_NUMBER = 2'd3
	} func_t;

	// Byte source for an emit step
	typedef enum logic [1:0] {
		SRC_CODE   = 2'd0,
		SRC_CURSOR = 2'd1,
		SRC_MINUS  = 2'd2,
		SRC_DIGIT  = 2'd3
	} src_t;

	// Datapath action of a step
	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_LOAD_MAG = 3'd1,
		ACT_MUL      = 3'd2,
		ACT_DIV      = 3'd3,
		ACT_POP      = 3'd4
	} act_t;

	// How the last flag of an emitted nibble is formed
	typedef enum logic [1:0] {
		LAST_NEVER   = 2'd0,
		LAST_ALWAYS  = 2'd1,
		LAST_IF_DONE = 2'd2
	} last_t;

	// Jump condition of a step
	typedef enum logic [2:0] {
		COND_NEXT       = 3'd0,
		COND_ALWAYS     = 3'd1,
		COND_DISPATCH   = 3'd2,
		COND_POSITIVE   = 3'd3,
		COND_CURSOR_BAD = 3'd4,
		COND_MORE       = 3'd5,
		COND_NOT_DONE   = 3'd6
	} cond_t;

	typedef logic [3:0] step_t;

	// Program addresses
	localparam step_t STEP_IDLE      = 4'd0;
	localparam step_t STEP_CMD_HI    = 4'd1;
	localparam step_t STEP_CMD_LO    = 4'd2;
	localparam step_t STEP_CHAR_HI   = 4'd3;
	localparam step_t STEP_CHAR_LO   = 4'd4;
	localparam step_t STEP_CUR_CHK   = 4'd5;
	localparam step_t STEP_CUR_HI    = 4'd6;
	localparam step_t STEP_CUR_LO    = 4'd7;
	localparam step_t STEP_NUM_LOAD  = 4'd8;
	localparam step_t STEP_MINUS_HI  = 4'd9;
	localparam step_t STEP_MINUS_LO  = 4'd10;
	localparam step_t STEP_DIV_MUL   = 4'd11;
	localparam step_t STEP_DIV_STORE = 4'd12;
	localparam step_t STEP_DIGIT_HI  = 4'd13;
	localparam step_t STEP_DIGIT_LO  = 4'd14;
	localparam step_t STEP_DONE      = 4'd15;

	// One control word
	typedef struct packed {
		logic  wait_in;
		logic  emit;
		logic  hi;
		logic  rs;
		src_t  src;
		act_t  act;
		last_t last_mode;
		cond_t cond;
		step_t target;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		logic  fire;
		logic  load_in;
		logic  emit;
		logic  hi;
		logic  rs;
		src_t  src;
		act_t  act;
		last_t last_mode;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic slot_free;
		logic neg;
		logic cursor_bad;
		logic more;
		logic one_left;
	} status_t;

	function automatic ucode_t mk_word(logic wait_in, logic emit, logic hi, logic rs,
			src_t src, act_t act, last_t last_mode, cond_t cond, step_t target);
		ucode_t w;
		w.wait_in   = wait_in;
		w.emit      = emit;
		w.hi        = hi;
		w.rs        = rs;
		w.src       = src;
		w.act       = act;
		w.last_mode = last_mode;
		w.cond      = cond;
		w.target    = target;
		return w;
	endfunction

	// Control store
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:      w = mk_word(1'b1, 1'b0, 1'b0, 1'b0, SRC_CODE, ACT_NONE,
					LAST_NEVER, COND_DISPATCH, STEP_IDLE);
			STEP_CMD_HI:    w = mk_word(1'b0, 1'b1, 1'b1, 1'b0, SRC_CODE, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_CMD_LO:    w = mk_word(1'b0, 1'b1, 1'b0, 1'b0, SRC_CODE, ACT_NONE,
					LAST_ALWAYS, COND_ALWAYS, STEP_IDLE);
			STEP_CHAR_HI:   w = mk_word(1'b0, 1'b1, 1'b1, 1'b1, SRC_CODE, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_CHAR_LO:   w = mk_word(1'b0, 1'b1, 1'b0, 1'b1, SRC_CODE, ACT_NONE,
					LAST_ALWAYS, COND_ALWAYS, STEP_IDLE);
			STEP_CUR_CHK:   w = mk_word(1'b0, 1'b0, 1'b0, 1'b0, SRC_CURSOR, ACT_NONE,
					LAST_NEVER, COND_CURSOR_BAD, STEP_IDLE);
			STEP_CUR_HI:    w = mk_word(1'b0, 1'b1, 1'b1, 1'b0, SRC_CURSOR, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_CUR_LO:    w = mk_word(1'b0, 1'b1, 1'b0, 1'b0, SRC_CURSOR, ACT_NONE,
					LAST_ALWAYS, COND_ALWAYS, STEP_IDLE);
			STEP_NUM_LOAD:  w = mk_word(1'b0, 1'b0, 1'b0, 1'b1, SRC_MINUS, ACT_LOAD_MAG,
					LAST_NEVER, COND_POSITIVE, STEP_DIV_MUL);
			STEP_MINUS_HI:  w = mk_word(1'b0, 1'b1, 1'b1, 1'b1, SRC_MINUS, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_MINUS_LO:  w = mk_word(1'b0, 1'b1, 1'b0, 1'b1, SRC_MINUS, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_DIV_MUL:   w = mk_word(1'b0, 1'b0, 1'b0, 1'b1, SRC_DIGIT, ACT_MUL,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_DIV_STORE: w = mk_word(1'b0, 1'b0, 1'b0, 1'b1, SRC_DIGIT, ACT_DIV,
					LAST_NEVER, COND_MORE, STEP_DIV_MUL);
			STEP_DIGIT_HI:  w = mk_word(1'b0, 1'b1, 1'b1, 1'b1, SRC_DIGIT, ACT_NONE,
					LAST_NEVER, COND_NEXT, STEP_IDLE);
			STEP_DIGIT_LO:  w = mk_word(1'b0, 1'b1, 1'b0, 1'b1, SRC_DIGIT, ACT_POP,
					LAST_IF_DONE, COND_NOT_DONE, STEP_DIGIT_HI);
			STEP_DONE:      w = mk_word(1'b0, 1'b0, 1'b0, 1'b0, SRC_CODE, ACT_NONE,
					LAST_NEVER, COND_ALWAYS, STEP_IDLE);
		endcase
		return w;
	endfunction

	// Entry point of each request kind
	function automatic step_t dispatch_step(func_t func);
		step_t s;
		unique case (func)
			FUNC_CMD:    s = STEP_CMD_HI;
			FUNC_CHAR:   s = STEP_CHAR_HI;
			FUNC_CURSOR: s = STEP_CUR_CHK;
			FUNC_NUMBER: s = STEP_NUM_LOAD;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/char_lcd_nibble_writer.sv -----
// Top level of the character LCD nibble writer.
// Depends on cln_pkg, cln_sequencer and cln_datapath.

// Turns one request (command byte, character byte, cursor move or signed
// integer) into the 4-bit transfers of a two-line character LCD, high nibble
// first, with reg_select 0 for commands and 1 for data and last set on the
// final nibble of the request. A cursor move outside rows 0..1 or columns
// 0..15 produces no transfer. A 16-step microprogram walks each request, one
// step per cycle while no step stalls for the output slot. A number sends a
// minus sign first if negative, then runs a divide-by-ten loop (multiply
// step, then store step, per digit) before its digit nibbles go out through
// the output register, which holds one nibble until it is taken. The
// sequencer is back at its idle step, ready for the next request, once it
// has handed the final nibble of the previous one to the output register
// (for a number, after a closing step), even while that nibble still waits
// to be taken.

module char_lcd_nibble_writer #(
	parameter int MAX_DIGITS = cln_pkg::MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [7:0]         code,
	input  logic signed [31:0] number,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               reg_select,
	output logic [3:0]         nibble,
	output logic               last
);

	cln_pkg::ctrl_t   ctrl;
	cln_pkg::status_t status;

	// Control sequencer
	cln_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	// Datapath and output register
	cln_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.code       (code),
		.number     (number),
		.row        (row),
		.col        (col),
		.out_ready  (out_ready),
		.status     (status),
		.out_valid  (out_valid),
		.reg_select (reg_select),
		.nibble     (nibble),
		.last       (last)
	);

endmodule

// ----- rtl/core/cln_sequencer.sv -----
// Step counter and control store walk for the character LCD nibble writer.
// Depends on cln_pkg (control store, step codes, control and status structs).

module cln_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       func,
	input  cln_pkg::status_t status,
	output logic             in_ready,
	output cln_pkg::ctrl_t   ctrl
);

	cln_pkg::step_t  step_q;
	cln_pkg::step_t  step_d;
	cln_pkg::ucode_t word;
	logic            stall;
	logic            taken;

	assign word = cln_pkg::ucode_rom(step_q);

	// A step holds while it waits for a request or for the output slot
	assign stall = (word.wait_in && !in_valid) || (word.emit && !status.slot_free);

	// Jump condition
	always_comb begin
		unique case (word.cond)
			cln_pkg::COND_NEXT:       taken = 1'b0;
			cln_pkg::COND_ALWAYS:     taken = 1'b1;
			cln_pkg::COND_DISPATCH:   taken = 1'b1;
			cln_pkg::COND_POSITIVE:   taken = !status.neg;
			cln_pkg::COND_CURSOR_BAD: taken = status.cursor_bad;
			cln_pkg::COND_MORE:       taken = status.more;
			cln_pkg::COND_NOT_DONE:   taken = !status.one_left;
			default:                  taken = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		priority if (stall) begin
			step_d = step_q;
		end else if (word.cond == cln_pkg::COND_DISPATCH) begin
			step_d = cln_pkg::dispatch_step(cln_pkg::func_t'(func));
		end else if (taken) begin
			step_d = word.target;
		end else begin
			step_d = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cln_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Outputs to the datapath
	always_comb begin
		in_ready       = (step_q == cln_pkg::STEP_IDLE);
		ctrl.fire      = !stall;
		ctrl.load_in   = word.wait_in && in_valid;
		ctrl.emit      = word.emit;
		ctrl.hi        = word.hi;
		ctrl.rs        = word.rs;
		ctrl.src       = word.src;
		ctrl.act       = word.act;
		ctrl.last_mode = word.last_mode;
	end

endmodule

// ----- rtl/core/cln_datapath.sv -----
// Request registers, divide-by-ten digit unit, digit stack and output register.
// Depends on cln_pkg (constants, control and status structs).

module cln_datapath #(
	parameter int MAX_DIGITS = cln_pkg::MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cln_pkg::ctrl_t     ctrl,
	input  logic [7:0]         code,
	input  logic signed [31:0] number,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	input  logic               out_ready,
	output cln_pkg::status_t   status,
	output logic               out_valid,
	output logic               reg_select,
	output logic [3:0]         nibble,
	output logic               last
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// Request registers
	logic [7:0]  code_q;
	logic [31:0] num_q;
	logic [7:0]  row_q;
	logic [7:0]  col_q;

	// Digit unit
	logic [31:0]      mag_q;
	logic [63:0]      prod_q;
	logic [CNT_W-1:0] count_q;
	logic [3:0]       digits_q [MAX_DIGITS];
	logic [31:0]      quot;
	logic [31:0]      quot_x10;
	logic [31:0]      rem;
	logic [CNT_W:0]   count_inc;
	logic [CNT_W-1:0] count_m1;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;

	// Output register
	logic       out_valid_q;
	logic       rs_q;
	logic [3:0] nibble_q;
	logic       last_q;
	logic       slot_free;
	logic [7:0] byte_sel;
	logic [7:0] cursor_byte;
	logic       last_d;

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.load_in) begin
			code_q <= code;
			num_q  <= $unsigned(number);
			row_q  <= row;
			col_q  <= col;
		end
	end

	// Quotient and remainder from the registered product
	assign quot      = {3'b000, prod_q[63:cln_pkg::RECIP_SHIFT]};
	assign quot_x10  = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
	assign rem       = mag_q - quot_x10;
	assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
	assign count_m1  = count_q - CNT_W'(1);
	assign rd_idx    = count_m1[IDX_W-1:0];
	assign wr_idx    = count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			unique case (ctrl.act)
				cln_pkg::ACT_LOAD_MAG: mag_q <= num_q[31] ? (32'd0 - num_q) : num_q;
				cln_pkg::ACT_MUL:      prod_q <= mag_q * cln_pkg::RECIP10;
				cln_pkg::ACT_DIV: begin
					mag_q            <= quot;
					digits_q[wr_idx] <= rem[3:0];
				end
				default: ;
			endcase
		end
	end

	// Digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.fire) begin
			unique case (ctrl.act)
				cln_pkg::ACT_LOAD_MAG: count_q <= '0;
				cln_pkg::ACT_DIV:      count_q <= count_inc[CNT_W-1:0];
				cln_pkg::ACT_POP:      count_q <= count_m1;
				default: ;
			endcase
		end
	end

	// Byte for the current emit step
	assign cursor_byte = cln_pkg::SET_DDRAM_CMD
		| (row_q[0] ? cln_pkg::ROW1_OFFSET : 8'h00) | {4'h0, col_q[3:0]};

	always_comb begin
		unique case (ctrl.src)
			cln_pkg::SRC_CODE:   byte_sel = code_q;
			cln_pkg::SRC_CURSOR: byte_sel = cursor_byte;
			cln_pkg::SRC_MINUS:  byte_sel = cln_pkg::MINUS_CHAR;
			cln_pkg::SRC_DIGIT:  byte_sel = {cln_pkg::DIGIT_HI, digits_q[rd_idx]};
		endcase
	end

	always_comb begin
		unique case (ctrl.last_mode)
			cln_pkg::LAST_ALWAYS:  last_d = 1'b1;
			cln_pkg::LAST_IF_DONE: last_d = (count_q == CNT_W'(1));
			default:               last_d = 1'b0;
		endcase
	end

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire && ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.emit) begin
			rs_q     <= ctrl.rs;
			nibble_q <= ctrl.hi ? byte_sel[7:4] : byte_sel[3:0];
			last_q   <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_select = rs_q;
	assign nibble     = nibble_q;
	assign last       = last_q;

	// Status back to the sequencer
	always_comb begin
		status.slot_free  = slot_free;
		status.neg        = num_q[31];
		status.cursor_bad = (row_q > cln_pkg::ROW_MAX) || (col_q > cln_pkg::COL_MAX);
		status.more       = (quot != 32'd0) && (count_inc < (CNT_W + 1)'(MAX_DIGITS));
		status.one_left   = (count_q == CNT_W'(1));
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond stack depth");

	a_digit_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fire && ctrl.emit && ctrl.src == cln_pkg::SRC_DIGIT) |-> (count_q != '0))
		else $error("digit emitted from empty stack");

	a_div_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fire && ctrl.act == cln_pkg::ACT_DIV)
		|-> $past(ctrl.fire && ctrl.act == cln_pkg::ACT_MUL))
		else $error("digit store without fresh product");
`endif

endmodule
